### rtl/fgrg_pkg.sv
// ----------------------------------------------------------------------------
// fgrg_pkg
// Shared constants for the falling glyph rain generator.
// ----------------------------------------------------------------------------
package fgrg_pkg;

    localparam int DEF_MAX_COLS = 132;
    localparam int DEF_MAX_ROWS = 25;

    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [15:0] DIM_ATTR   = 16'h0200;
    localparam logic [15:0] BOLD_ATTR  = 16'h0A00;
    localparam logic [15:0] BLANK_WORD = 16'h0220;
    localparam logic [7:0]  SPACE_CHAR = 8'h20;
    localparam logic [7:0]  RATE_MOD   = 8'hE0;
    localparam logic [7:0]  RATE_BASE  = 8'h10;
    localparam logic [7:0]  GLYPH_MOD  = 8'd94;
    localparam logic [7:0]  GLYPH_BASE = 8'd33;

    // x / 94 = (x * GLYPH_RECIP) >> 23, (x >> 5) / 7 = ((x >> 5) * RATE_RECIP) >> 14
    localparam logic [16:0] GLYPH_RECIP = 17'd89241;
    localparam logic [11:0] RATE_RECIP  = 12'd2341;

    localparam logic [1:0] FUNC_SEED   = 2'd0;
    localparam logic [1:0] FUNC_INIT   = 2'd1;
    localparam logic [1:0] FUNC_STEP   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [2:0] REG_ROWS = 3'd0;
    localparam logic [2:0] REG_COLS = 3'd4;

endpackage

### rtl/falling_glyph_rain_generator_top.sv
// ----------------------------------------------------------------------------
// falling_glyph_rain_generator_top
// Text-mode falling glyph generator: per-column head/trail state, LFSR glyphs.
// ----------------------------------------------------------------------------
// One item at a time; the block takes no new item until the last is done.
// An advance may step the head a row and may draw the column again. The
// two modulo operations of a draw, by twice the row count and by the row
// count, run on a shared restoring divider, one quotient bit per cycle;
// the constant moduli (224 for the rate, 94 for the glyph) use a
// reciprocal multiply for the quotient and a multiply-subtract for the
// remainder. Result words leave one per cycle while the receiver does
// not stall.
// Per-column state lives in small memories with a registered read;
// a valid bit per column makes a never-drawn column read as its reset values,
// so reset needs no clearing pass.
module falling_glyph_rain_generator_top
    import fgrg_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_column,
    input  logic [15:0] i_seed_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_write_en,
    output logic [4:0]  o_cell_row,
    output logic [7:0]  o_cell_col,
    output logic [15:0] o_cell_word,
    output logic        o_last
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_DR0, S_DR1, S_DR2, S_STEP, S_GLYPH, S_EMIT, S_DIV, S_CQ, S_CR,
        S_OUT
    } t_state;

    t_state r_state, r_ret;

    logic [4:0]  r_rows_reg;
    logic [7:0]  r_cols_reg;
    logic [15:0] r_lfsr;

    logic signed [6:0] m_head  [MAX_COLS];
    logic [4:0]        m_len   [MAX_COLS];
    logic [7:0]        m_rate  [MAX_COLS];
    logic [8:0]        m_phase [MAX_COLS];
    logic [7:0]        m_glyph [MAX_COLS];
    logic [MAX_COLS-1:0] r_gvalid;

    logic signed [6:0] r_rd_head;
    logic [4:0]  r_rd_len;
    logic [7:0]  r_rd_rate;
    logic [8:0]  r_rd_phase;
    logic [7:0]  r_rd_glyph;

    logic signed [6:0] r_head;
    logic [4:0]  r_len;
    logic [7:0]  r_rate;
    logic [8:0]  r_phase;
    logic [7:0]  r_glyph;
    logic        r_gv;

    logic [CW-1:0] r_col;
    logic [7:0]    r_col8;
    logic [1:0]    r_func;
    logic [4:0]    r_rows;

    // divider
    logic [15:0] r_dq;
    logic [8:0]  r_drem;
    logic [5:0]  r_dden;
    logic [4:0]  r_dcnt;
    logic [9:0]  r_cq;

    // result queue (up to three)
    logic [4:0]  r_qrow  [3];
    logic [15:0] r_qword [3];
    logic [1:0]  r_qn;
    logic [1:0]  r_qi;

    logic [1:0]  r_step;     // which draw step / which phase of advance
    logic        r_we;       // write state back
    logic [7:0]  r_prev;
    logic [15:0] s_lnext;
    logic [9:0]  s_trial;
    logic signed [7:0] s_tail;
    logic [8:0]  s_psum;
    logic [32:0] s_m94;
    logic [22:0] s_m224;
    logic [15:0] s_cprod;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr)
            REG_ROWS: prdata = {27'd0, r_rows_reg};
            REG_COLS: prdata = {24'd0, r_cols_reg};
            default:  prdata = 32'd0;
        endcase
    end

    assign s_lnext = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : 16'd0);
    assign s_trial = {r_drem, r_dq[15]} - {4'd0, r_dden};
    assign s_tail  = 8'(r_head) - 8'sd1 - $signed({3'd0, r_len});
    assign s_psum  = r_phase + {1'b0, r_rate};
    assign s_m94   = {17'd0, r_dq} * {16'd0, GLYPH_RECIP};
    assign s_m224  = {12'd0, r_dq[15:5]} * {11'd0, RATE_RECIP};
    assign s_cprod = (r_step == 2'd2) ? ({6'd0, r_cq} * {8'd0, GLYPH_MOD}) :
                                        ({6'd0, r_cq} * {8'd0, RATE_MOD});

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_reg <= 5'd25;
            r_cols_reg <= 8'd80;
        end else if (psel && penable && pwrite) begin
            if (paddr == REG_ROWS) r_rows_reg <= pwdata[4:0];
            if (paddr == REG_COLS) r_cols_reg <= pwdata[7:0];
        end
    end

    // state memories
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_rd_head  <= m_head[CW'(i_column)];
            r_rd_len   <= m_len[CW'(i_column)];
            r_rd_rate  <= m_rate[CW'(i_column)];
            r_rd_phase <= m_phase[CW'(i_column)];
            r_rd_glyph <= m_glyph[CW'(i_column)];
        end
        if (r_we) begin
            m_head[r_col]  <= r_head;
            m_len[r_col]   <= r_len;
            m_rate[r_col]  <= r_rate;
            m_phase[r_col] <= r_phase;
            m_glyph[r_col] <= r_glyph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_lfsr   <= 16'd1;
            r_gvalid <= '0;
            r_we     <= 1'b0;
            r_qn     <= 2'd0;
            r_qi     <= 2'd0;
            r_step   <= 2'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_func <= i_func;
                    r_col  <= CW'(i_column);
                    r_col8 <= i_column;
                    r_rows <= (int'(r_rows_reg) > MAX_ROWS) ? 5'(MAX_ROWS) :
                              (r_rows_reg == 5'd0) ? 5'd1 : r_rows_reg;
                    r_gv   <= r_gvalid[CW'(i_column)];
                    r_qn   <= 2'd0;
                    r_qi   <= 2'd0;
                    if (i_valid) begin
                        if (i_func == FUNC_SEED) begin
                            r_lfsr <= ((r_lfsr + i_seed_value) == 16'd0) ? 16'd1
                                      : r_lfsr + i_seed_value;
                            r_state <= S_OUT;
                        end else if (i_func == FUNC_UNUSED || i_column >= r_cols_reg ||
                                     32'(i_column) >= MAX_COLS) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_head  <= r_gv ? r_rd_head : 7'sd0;
                    r_len   <= r_gv ? r_rd_len : 5'd0;
                    r_rate  <= r_gv ? r_rd_rate : 8'd0;
                    r_phase <= (r_gv && r_func != FUNC_INIT) ? r_rd_phase : 9'd0;
                    r_glyph <= r_gv ? r_rd_glyph : SPACE_CHAR;
                    r_state <= (r_func == FUNC_INIT) ? S_DR0 : S_STEP;
                end
                S_DR0: begin
                    r_lfsr <= s_lnext;
                    r_dq <= s_lnext; r_drem <= 9'd0; r_dcnt <= 5'd16;
                    r_dden <= {r_rows, 1'b0};
                    r_ret <= S_DR1; r_state <= S_DIV;
                end
                S_DR1: begin
                    r_head <= 7'(r_drem) - 7'(r_rows);
                    r_lfsr <= s_lnext;
                    r_dq <= s_lnext; r_drem <= 9'd0; r_dcnt <= 5'd16;
                    r_dden <= {1'b0, r_rows};
                    r_ret <= S_DR2; r_state <= S_DIV;
                end
                S_DR2: begin
                    if (r_step == 2'd0) begin
                        r_len <= r_drem[4:0];
                        r_lfsr <= s_lnext;
                        r_dq <= s_lnext;
                        r_step <= 2'd1;
                        r_ret <= S_DR2; r_state <= S_CQ;
                    end else begin
                        r_rate  <= 8'(r_drem) + RATE_BASE;
                        r_glyph <= SPACE_CHAR;
                        r_gvalid[r_col] <= 1'b1;
                        r_we    <= 1'b1;
                        r_step  <= 2'd0;
                        r_state <= S_OUT;
                    end
                end
                S_STEP: begin
                    r_prev <= r_glyph;
                    if (s_psum[8]) begin
                        r_phase <= {1'b0, s_psum[7:0]};
                        r_head  <= r_head + 7'sd1;
                        r_state <= S_GLYPH;
                    end else begin
                        r_phase <= s_psum;
                        r_we    <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_GLYPH: begin
                    if (r_head >= 0 && r_head < $signed({2'd0, r_rows})) begin
                        r_lfsr <= s_lnext;
                        r_dq <= s_lnext;
                        r_step <= 2'd2;
                        r_ret <= S_EMIT; r_state <= S_CQ;
                    end else begin
                        r_step  <= 2'd0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (r_head < 0) begin
                        r_we <= 1'b1;
                        r_step <= 2'd0;
                        r_state <= S_OUT;
                    end else begin
                        logic [1:0] n;
                        n = 2'd0;
                        if (r_step == 2'd2) begin
                            r_glyph <= 8'(r_drem) + GLYPH_BASE;
                            r_gvalid[r_col] <= 1'b1;
                            r_qrow[0]  <= 5'(r_head);
                            r_qword[0] <= {8'd0, 8'(r_drem) + GLYPH_BASE} | BOLD_ATTR;
                            n = 2'd1;
                        end
                        if (r_head >= 7'sd1 && r_head <= $signed({2'd0, r_rows})) begin
                            r_qrow[n]  <= 5'(r_head - 7'sd1);
                            r_qword[n] <= {8'd0, r_prev} | DIM_ATTR;
                            n = n + 2'd1;
                        end
                        r_step <= 2'd0;
                        if (s_tail >= $signed({3'd0, r_rows})) begin
                            r_qn <= n;
                            r_state <= S_DR0;
                        end else begin
                            if (s_tail >= 0) begin
                                r_qrow[n]  <= 5'(s_tail);
                                r_qword[n] <= BLANK_WORD;
                                n = n + 2'd1;
                            end
                            r_qn <= n;
                            r_we <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_DIV: begin
                    r_dq <= {r_dq[14:0], 1'b0};
                    if (!s_trial[9]) r_drem <= s_trial[8:0];
                    else r_drem <= {r_drem[7:0], r_dq[15]};
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == 5'd1) r_state <= r_ret;
                end
                S_CQ: begin
                    r_cq <= (r_step == 2'd2) ? s_m94[32:23] : {1'b0, s_m224[22:14]};
                    r_state <= S_CR;
                end
                S_CR: begin
                    r_drem <= 9'(r_dq - s_cprod);
                    r_state <= r_ret;
                end
                S_OUT: begin
                    r_we <= 1'b0;
                    if (!i_stall) begin
                        if (r_qi + 2'd1 >= r_qn) r_state <= S_IDLE;
                        else r_qi <= r_qi + 2'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_write_en  = (r_qn != 2'd0);
    assign o_cell_row  = (r_qn != 2'd0) ? r_qrow[r_qi] : 5'd0;
    assign o_cell_col  = (r_qn != 2'd0) ? r_col8 : 8'd0;
    assign o_cell_word = (r_qn != 2'd0) ? r_qword[r_qi] : 16'd0;
    assign o_last      = (r_qn == 2'd0) || (r_qi + 2'd1 >= r_qn);

    a_lfsr_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != 16'd0) else $error("lfsr zero");
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("valid while idle");
    a_qi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_qn != 2'd0 |-> r_qi < r_qn) else $error("queue index");

endmodule

### sim/fgrg_checker.sv
// ----------------------------------------------------------------------------
// fgrg_checker
// Watches the item and cell channels of the glyph rain generator, predicts
// the cell words each accepted item causes and compares them in order.
// ----------------------------------------------------------------------------
module fgrg_checker
    import fgrg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_column,
    input  logic [15:0] i_seed_value,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_write_en,
    input  logic [4:0]  i_cell_row,
    input  logic [7:0]  i_cell_col,
    input  logic [15:0] i_cell_word,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic        we;
        logic [4:0]  row;
        logic [7:0]  col;
        logic [15:0] word;
        logic        last;
    } cell_t;

    cell_t       cell_q[$];
    logic [4:0]  rows_reg;
    logic [7:0]  cols_reg;
    logic [15:0] lfsr;
    int          head[DEF_MAX_COLS];
    logic [4:0]  tlen[DEF_MAX_COLS];
    logic [7:0]  rate[DEF_MAX_COLS];
    logic [8:0]  phase[DEF_MAX_COLS];
    logic [7:0]  glyph[DEF_MAX_COLS];

    assign o_pending = cell_q.size();

    function automatic int lfsr_next();
        lfsr = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 16'h0);
        return int'(lfsr);
    endfunction

    function automatic void redraw(int c, int r);
        head[c] = (lfsr_next() % (2 * r)) - r;
        tlen[c] = 5'(lfsr_next() % r);
        rate[c] = 8'(lfsr_next() % int'(RATE_MOD) + int'(RATE_BASE));
        glyph[c] = SPACE_CHAR;
    endfunction

    function automatic void push_cell(int r, int c, logic [15:0] w);
        cell_t e;
        e.we = 1'b1; e.row = 5'(r); e.col = 8'(c); e.word = w; e.last = 1'b0;
        cell_q.push_back(e);
    endfunction

    function automatic void predict_item(logic [1:0] f, int c, logic [15:0] s);
        int    r, cmax, ph, t, n0, g;
        logic [7:0] prev;
        cell_t e;
        r = (rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows_reg);
        if (r == 0) r = 1;
        cmax = (cols_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols_reg);
        n0 = cell_q.size();
        if (f == FUNC_SEED) begin
            lfsr = lfsr + s;
            if (lfsr == 16'h0) lfsr = 16'h1;
        end else if (c < cmax) begin
            if (f == FUNC_INIT) begin
                redraw(c, r);
                phase[c] = 9'h0;
            end else if (f == FUNC_STEP) begin
                ph = int'(phase[c]) + int'(rate[c]);
                if (ph & 'h100) begin
                    ph -= 'h100;
                    head[c] += 1;
                    if (head[c] >= 0) begin
                        prev = glyph[c];
                        if (head[c] < r) begin
                            g = lfsr_next() % int'(GLYPH_MOD) + int'(GLYPH_BASE);
                            glyph[c] = 8'(g);
                            push_cell(head[c], c, {8'h0, 8'(g)} | BOLD_ATTR);
                        end
                        if (head[c] >= 1 && head[c] - 1 < r)
                            push_cell(head[c] - 1, c, {8'h0, prev} | DIM_ATTR);
                        t = head[c] - 1 - int'(tlen[c]);
                        if (t >= r) redraw(c, r);
                        else if (t >= 0) push_cell(t, c, BLANK_WORD);
                    end
                end
                phase[c] = 9'(ph);
            end
        end
        if (cell_q.size() == n0) begin
            e = '0; e.last = 1'b1;
            cell_q.push_back(e);
        end else begin
            cell_q[$].last = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        cell_t got, want;
        if (!i_rst_n) begin
            rows_reg <= 5'd25;
            cols_reg <= 8'd80;
            lfsr = 16'h1;
            for (int i = 0; i < DEF_MAX_COLS; i++) begin
                head[i] = 0; tlen[i] = '0; rate[i] = '0; phase[i] = '0;
                glyph[i] = SPACE_CHAR;
            end
            cell_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we && i_cfg_addr == REG_ROWS) rows_reg <= i_cfg_data[4:0];
            if (i_cfg_we && i_cfg_addr == REG_COLS) cols_reg <= i_cfg_data[7:0];
            if (i_out_valid && !i_out_stall) begin
                got = '{i_write_en, i_cell_row, i_cell_col, i_cell_word, i_last};
                if (cell_q.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected word %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = cell_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp we=%b row=%0d col=%0d word=%h last=%b, got we=%b row=%0d col=%0d word=%h last=%b",
                                want.we, want.row, want.col, want.word, want.last,
                                got.we, got.row, got.col, got.word, got.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_item(i_func, int'(i_column), i_seed_value);
        end
    end
endmodule

### sim/tb_falling_glyph_rain_generator_top.sv
// ----------------------------------------------------------------------------
// tb_falling_glyph_rain_generator_top
// Drives seed, init, step and unused items and register settings into the glyph rain
// generator with random gaps and stalls; the checker compares every word.
// ----------------------------------------------------------------------------
module tb_falling_glyph_rain_generator_top;
    import fgrg_pkg::*;

    logic        i_clk, i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        i_valid, o_stall;
    logic [1:0]  i_func;
    logic [7:0]  i_column;
    logic [15:0] i_seed_value;
    logic        o_valid, i_stall;
    logic        o_write_en, o_last;
    logic [4:0]  o_cell_row;
    logic [7:0]  o_cell_col;
    logic [15:0] o_cell_word;
    int          fail_count, pending;
    int          cols_now;

    falling_glyph_rain_generator_top dut (.*);

    fgrg_checker chk (
        .i_clk, .i_rst_n,
        .i_cfg_we(psel && penable && pwrite && pready),
        .i_cfg_addr(paddr), .i_cfg_data(pwdata),
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_func, .i_column, .i_seed_value,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_write_en(o_write_en), .i_cell_row(o_cell_row), .i_cell_col(o_cell_col),
        .i_cell_word(o_cell_word), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("FAIL falling_glyph_rain_generator_top");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // receiver stall pattern
    initial begin
        i_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            repeat (gap_len()) @(posedge i_clk);
            i_stall <= 1'b1;
            repeat ($urandom_range(1, 2) + (($urandom_range(0, 9) == 0) ? 60 : 0))
                @(posedge i_clk);
            i_stall <= 1'b0;
            if ($urandom_range(0, 7) == 0) repeat (300) @(posedge i_clk);
        end
    end

    task automatic reg_write(logic [2:0] a, logic [31:0] d);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(logic [1:0] f, logic [7:0] c, logic [15:0] s);
        i_valid <= 1'b1; i_func <= f; i_column <= c; i_seed_value <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if ($urandom_range(0, 2) != 0) begin
            i_valid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic random_item();
        int p;
        logic [7:0] c;
        p = $urandom_range(0, 99);
        c = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, cols_now - 1));
        if (p < 8) send_item(FUNC_SEED, 8'($urandom), 16'($urandom));
        else if (p < 25) send_item(FUNC_INIT, c, 16'($urandom));
        else if (p < 97) send_item(FUNC_STEP, c, 16'($urandom));
        else send_item(FUNC_UNUSED, c, 16'($urandom));
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0; i_func = '0; i_column = '0; i_seed_value = '0;
        cols_now = 80;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send_item(FUNC_STEP, 8'd0, 16'h0);
        send_item(FUNC_SEED, 8'd0, 16'hFFFF);
        send_item(FUNC_SEED, 8'd0, 16'hFFFF);
        send_item(FUNC_SEED, 8'd0, 16'h0001);
        send_item(FUNC_SEED, 8'd0, 16'h5AA5);
        send_item(FUNC_INIT, 8'd0, 16'h0);
        send_item(FUNC_INIT, 8'd79, 16'h0);
        send_item(FUNC_INIT, 8'd80, 16'h0);
        send_item(FUNC_INIT, 8'd255, 16'hFFFF);
        send_item(FUNC_UNUSED, 8'd0, 16'h0);
        repeat (12) send_item(FUNC_STEP, 8'd0, 16'h0);
        send_item(FUNC_STEP, 8'd79, 16'h0);
        drain();

        reg_write(REG_ROWS, 32'd0);
        reg_write(REG_COLS, 32'd132);
        cols_now = 132;
        send_item(FUNC_INIT, 8'd131, 16'h0);
        repeat (6) send_item(FUNC_STEP, 8'd131, 16'h0);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin reg_write(REG_ROWS, 32'd25); reg_write(REG_COLS, 32'd4); end
                1: begin reg_write(REG_ROWS, 32'd1); reg_write(REG_COLS, 32'd132); end
                2: begin reg_write(REG_ROWS, 32'd31); reg_write(REG_COLS, 32'd255); end
                3: begin reg_write(REG_ROWS, 32'd3); reg_write(REG_COLS, 32'd1); end
                default: begin reg_write(REG_ROWS, 32'd12); reg_write(REG_COLS, 32'd8); end
            endcase
            cols_now = (ph == 0) ? 4 : (ph == 1) ? 132 : (ph == 2) ? 132 :
                       (ph == 3) ? 1 : 8;
            for (int c = 0; c < cols_now && c < 8; c++) send_item(FUNC_INIT, 8'(c), 16'h0);
            repeat (70) random_item();
            drain();
        end
        drain();
        if (fail_count == 0) $display("PASS falling_glyph_rain_generator_top");
        else $display("FAIL falling_glyph_rain_generator_top");
        $finish;
    end
endmodule
